### rtl/bsss_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the scene selection core
package bsss_pkg;
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_MISS   = 2'd1;
    localparam logic [1:0] OP_SELECT = 2'd2;
    localparam logic [0:0] REG_RES   = 1'd0;
    localparam logic [0:0] REG_COST  = 1'd1;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 16;
    localparam int CFG_W  = 16;
    localparam int MISS_NUM = 19 * 65536;
endpackage

### rtl/bsss_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces
interface bsss_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  scene_index;
    logic [15:0] path_length;
    modport source (output valid, operation, scene_index, path_length, input ready);
    modport sink (input valid, operation, scene_index, path_length, output ready);
endinterface

interface bsss_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  chosen_index;
    logic [15:0] chosen_belief;
    modport source (output valid, chosen_index, chosen_belief, input ready);
    modport sink (input valid, chosen_index, chosen_belief, output ready);
endinterface

### rtl/bsss_div.sv
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle, half-up rounding
module bsss_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [32:0] quot
);
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [63:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [32:0] q_reg, q_next;
    logic [33:0] trial;
    logic [32:0] shifted;

    // numerator is (num << 16) + den/2, 49 bits
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        done      = 1'b0;
        shifted   = {rem_reg[31:0], num_reg[48]};
        trial     = {1'b0, shifted} - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd49;
            num_next  = {15'd0, {num, 17'd0} >> 1} + {33'd0, den[31:1]};
            rem_next  = '0;
            den_next  = {1'b0, den};
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[62:0], 1'b0};
            if (!trial[33])
            begin
                rem_next = trial[32:0];
                q_next   = {q_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                q_next   = {q_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quot = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end
endmodule

### rtl/bayes_search_scene_select_core.sv
`timescale 1ns / 1ps
// top level of the bayesian scene selection core
// req channel takes operation, scene_index and path_length; res channel
// returns chosen_index and chosen_belief for select requests only.
// load requests and unused operations finish when taken. a miss request
// with an in-range scene_index runs one division for the updated belief,
// a sum pass and, if the sum is nonzero, one division per scene for
// renormalization on the shared divider. a select request walks the scenes
// with one 33x16 cross product pair per scene through S_SDEN, S_SMUL, S_SCMP.
// req ready is low while a request is in work. a result waits in the
// output register while the receiver stalls; loads and misses are taken
// meanwhile, and a following select holds in its last step until the
// result leaves.
// reset sets all beliefs to floor(65536/SCENE_COUNT) capped at 65535, all lengths to zero,
// cell_resolution to 3277 and analysis_cost to 60.
module bayes_search_scene_select_core #(
    parameter int SCENE_COUNT = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    bsss_req_if.sink              req,
    bsss_res_if.source            res
);
    localparam int SW = (SCENE_COUNT > 1) ? $clog2(SCENE_COUNT) : 1;
    localparam int CW = SW + 1;
    localparam logic [15:0] UNIFORM =
        (65536 / SCENE_COUNT > 65535) ? 16'hffff : 16'(65536 / SCENE_COUNT);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MDIV  = 4'd1;
    localparam logic [3:0] S_MWAIT = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_NDIV  = 4'd4;
    localparam logic [3:0] S_NWAIT = 4'd5;
    localparam logic [3:0] S_SDEN  = 4'd6;
    localparam logic [3:0] S_SMUL  = 4'd7;
    localparam logic [3:0] S_SCMP  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [15:0] bel_reg [SCENE_COUNT];
    logic [15:0] len_reg [SCENE_COUNT];
    logic [15:0] res_cfg_reg;
    logic [7:0]  cost_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] tgt_reg, tgt_next;
    logic [31:0] sum_reg, sum_next;
    logic [32:0] dcur_reg, dcur_next;
    logic [32:0] dbest_reg, dbest_next;
    logic [15:0] bbest_reg, bbest_next;
    logic [SW-1:0] ibest_reg, ibest_next;
    logic [48:0] pa_reg, pa_next, pb_reg, pb_next;
    logic        ovalid_reg, ovalid_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic [15:0] obel_reg, obel_next;
    logic        dstart;
    logic [31:0] dnum, dden;
    logic        ddone;
    logic [32:0] dquot;
    logic        bel_we;
    logic [SW-1:0] bel_wa;
    logic [15:0] bel_wd;
    logic [SW-1:0] cidx;
    logic [32:0] draw;
    logic [20:0] bt;

    bsss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (dden),
        .done  (ddone),
        .quot  (dquot)
    );

    assign cidx = cnt_reg[SW-1:0];
    assign req.ready = (state_reg == S_IDLE);
    assign res.valid = ovalid_reg;
    assign res.chosen_index = oidx_reg;
    assign res.chosen_belief = obel_reg;
    assign bt = {5'd0, bel_reg[tgt_reg]} * 21'd18;
    assign draw = 33'(len_reg[cidx]) * 33'(res_cfg_reg) + {9'd0, cost_reg, 16'd0};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        tgt_next    = tgt_reg;
        sum_next    = sum_reg;
        dcur_next   = dcur_reg;
        dbest_next  = dbest_reg;
        bbest_next  = bbest_reg;
        ibest_next  = ibest_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        ovalid_next = ovalid_reg && !res.ready;
        oidx_next   = oidx_reg;
        obel_next   = obel_reg;
        dstart      = 1'b0;
        dnum        = {16'd0, bel_reg[tgt_reg]};
        dden        = 32'(bsss_pkg::MISS_NUM) - {11'd0, bt};
        bel_we      = 1'b0;
        bel_wa      = tgt_reg;
        bel_wd      = dquot[15:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    tgt_next = SW'(req.scene_index);
                    cnt_next = '0;
                    if (req.operation == bsss_pkg::OP_MISS
                        && 32'(req.scene_index) < SCENE_COUNT)
                        state_next = S_MDIV;
                    else if (req.operation == bsss_pkg::OP_SELECT)
                        state_next = S_SDEN;
                end
            end
            S_MDIV:
            begin
                dstart     = 1'b1;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (ddone)
                begin
                    bel_we     = 1'b1;
                    state_next = S_SUM;
                    sum_next   = '0;
                    cnt_next   = '0;
                end
            end
            S_SUM:
            begin
                sum_next = sum_reg + 32'(bel_reg[cidx]);
                if (cnt_reg == CW'(SCENE_COUNT - 1))
                begin
                    cnt_next = '0;
                    if (sum_next == '0)
                        state_next = S_IDLE;
                    else
                        state_next = S_NDIV;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_NDIV:
            begin
                dstart     = 1'b1;
                dnum       = {16'd0, bel_reg[cidx]};
                dden       = sum_reg;
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (ddone)
                begin
                    bel_we = 1'b1;
                    bel_wa = cidx;
                    bel_wd = (dquot > 33'd65535) ? 16'hffff : dquot[15:0];
                    if (cnt_reg == CW'(SCENE_COUNT - 1))
                        state_next = S_IDLE;
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_NDIV;
                    end
                end
            end
            S_SDEN:
            begin
                dcur_next = (draw == '0) ? 33'd1 : draw;
                if (cnt_reg == '0)
                begin
                    dbest_next = (draw == '0) ? 33'd1 : draw;
                    bbest_next = bel_reg[0];
                    ibest_next = '0;
                    cnt_next   = cnt_reg + 1'b1;
                end
                else
                    state_next = S_SMUL;
            end
            S_SMUL:
            begin
                pa_next    = 49'(bel_reg[cidx]) * 49'(dbest_reg);
                pb_next    = 49'(bbest_reg) * 49'(dcur_reg);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (pa_reg >= pb_reg)
                begin
                    dbest_next = dcur_reg;
                    bbest_next = bel_reg[cidx];
                    ibest_next = cidx;
                end
                if (cnt_reg == CW'(SCENE_COUNT - 1))
                begin
                    // hold until the output register is free
                    if (!ovalid_reg || res.ready)
                    begin
                        ovalid_next = 1'b1;
                        oidx_next   = (pa_reg >= pb_reg) ? 4'(cidx) : 4'(ibest_reg);
                        obel_next   = (pa_reg >= pb_reg) ? bel_reg[cidx] : bbest_reg;
                        state_next  = S_IDLE;
                    end
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_SDEN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ovalid_reg  <= 1'b0;
            res_cfg_reg <= 16'd3277;
            cost_reg    <= 8'd60;
            cnt_reg     <= '0;
            for (int i = 0; i < SCENE_COUNT; i++)
            begin
                bel_reg[i] <= UNIFORM;
                len_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            if (cfg_we)
            begin
                if (cfg_index == bsss_pkg::REG_RES)
                    res_cfg_reg <= cfg_data;
                else
                    cost_reg <= cfg_data[7:0];
            end
            if (bel_we)
                bel_reg[bel_wa] <= bel_wd;
            if (req.valid && req.ready && req.operation == bsss_pkg::OP_LOAD
                && 32'(req.scene_index) < SCENE_COUNT)
                len_reg[SW'(req.scene_index)] <= req.path_length;
        end
    end

    always_ff @(posedge clk)
    begin
        tgt_reg   <= tgt_next;
        sum_reg   <= sum_next;
        dcur_reg  <= dcur_next;
        dbest_reg <= dbest_next;
        bbest_reg <= bbest_next;
        ibest_reg <= ibest_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        oidx_reg  <= oidx_next;
        obel_reg  <= obel_next;
    end
endmodule
